[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off during reset.
`define SEVQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion, checked during reset too.
`define SEVQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[sv/sevq_pkg.sv]
// Package: entry type, operation codes and controller/datapath interface types.
`default_nettype none
package sevq_pkg;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_RECOVER = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    localparam logic [7:0] THRESHOLD_RESET = 8'd5;

    typedef struct packed {
        logic [31:0] event_time;
        logic [31:0] seq_id;
        logic [2:0]  thread_id;
        logic        speculative;
        logic        is_load;
        logic [31:0] issue_time;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd;
        logic eval;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic fin;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[sv/sevq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sevq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[sv/sevq_ctrl.sv]
// Controller: sequences load, read, evaluate and result hand-off.
`default_nettype none
module sevq_ctrl
    import sevq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = i_stat.fin ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_READ;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

[sv/sevq_dp.sv]
// Datapath: entry RAM, scan index, counters and the result register.
`default_nettype none
module sevq_dp
    import sevq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [1:0]  i_mode,
    input  wire t_entry      i_entry,
    input  wire logic [31:0] i_current_cycle,
    input  wire logic        i_cfg_valid,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_entry           o_head,
    output logic             o_head_valid,
    output logic             o_insert_dropped,
    output logic [4:0]       o_removed_count,
    output logic             o_miss_pending,
    output logic [4:0]       o_occupancy
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    logic [1:0]    r_mode;
    t_entry        r_req;
    logic [31:0]   r_cycle;
    logic [CW-1:0] r_idx, r_kept, r_rem, r_cnt;
    logic          r_placed, r_hv, r_hit, r_drop;
    t_entry        r_head;
    logic [7:0]    r_thr;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;
    logic          fin, key_lt, match_rec, match_qry;
    logic [31:0]   age;

    sevq_ram #(.WIDTH($bits(t_entry)), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign key_lt = (r_req.event_time < rdata.event_time) ||
                    ((r_req.event_time == rdata.event_time) && (r_req.seq_id < rdata.seq_id));
    assign match_rec = (rdata.thread_id == r_req.thread_id) && rdata.speculative;
    assign age       = r_cycle - rdata.issue_time;
    assign match_qry = (rdata.thread_id == r_req.thread_id) && rdata.is_load &&
                       (r_cycle >= rdata.issue_time) && (age > {24'd0, r_thr});

    always_comb begin
        case (r_mode)
            MODE_INSERT:  fin = (r_cnt == FULL) || r_placed || (r_idx == '0);
            MODE_QUERY:   fin = r_hit || (r_idx == r_cnt);
            default:      fin = (r_idx == r_cnt);
        endcase
    end

    assign o_stat.fin      = fin;
    assign o_stat.out_free = !o_valid || i_ready;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = rdata;
        re    = i_cmd.rd && !fin;
        raddr = (r_mode == MODE_INSERT) ? AW'(r_idx - CW'(1)) : r_idx[AW-1:0];
        if (i_cmd.rd && fin && r_mode == MODE_INSERT && r_cnt != FULL && !r_placed) begin
            we    = 1'b1;
            wdata = r_req;
        end
        if (i_cmd.eval) begin
            case (r_mode)
                MODE_INSERT: begin
                    we    = 1'b1;
                    wdata = key_lt ? rdata : r_req;
                end
                MODE_EXTRACT: begin
                    we    = (r_idx != '0);
                    waddr = AW'(r_idx - CW'(1));
                end
                MODE_RECOVER: begin
                    we    = !match_rec;
                    waddr = r_kept[AW-1:0];
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_req    <= i_entry;
            r_cycle  <= i_current_cycle;
            r_idx    <= (i_mode == MODE_INSERT) ? r_cnt : '0;
            r_kept   <= '0;
            r_rem    <= '0;
            r_placed <= 1'b0;
            r_hv     <= 1'b0;
            r_hit    <= 1'b0;
            r_drop   <= 1'b0;
        end
        if (i_cmd.eval) begin
            case (r_mode)
                MODE_INSERT: begin
                    if (key_lt) begin
                        r_idx <= r_idx - CW'(1);
                    end else begin
                        r_placed <= 1'b1;
                    end
                end
                MODE_EXTRACT: begin
                    if (r_idx == '0) begin
                        r_hv   <= 1'b1;
                        r_head <= rdata;
                    end
                    r_idx <= r_idx + CW'(1);
                end
                MODE_RECOVER: begin
                    if (match_rec) begin
                        r_rem <= r_rem + CW'(1);
                    end else begin
                        r_kept <= r_kept + CW'(1);
                    end
                    r_idx <= r_idx + CW'(1);
                end
                default: begin
                    r_hit <= match_qry;
                    r_idx <= r_idx + CW'(1);
                end
            endcase
        end
        if (i_cmd.rd && fin && r_mode == MODE_INSERT && r_cnt == FULL) begin
            r_drop <= 1'b1;
        end
        if (i_cmd.emit) begin
            o_head           <= (r_mode == MODE_EXTRACT && r_hv) ? r_head : '0;
            o_head_valid     <= (r_mode == MODE_EXTRACT) && r_hv;
            o_insert_dropped <= r_drop;
            o_removed_count  <= (r_mode == MODE_RECOVER) ? 5'(r_rem) : 5'd0;
            o_miss_pending   <= (r_mode == MODE_QUERY) && r_hit;
            o_occupancy      <= 5'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_thr   <= THRESHOLD_RESET;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.rd && fin) begin
                case (r_mode)
                    MODE_INSERT:  if (r_cnt != FULL) r_cnt <= r_cnt + CW'(1);
                    MODE_EXTRACT: if (r_hv) r_cnt <= r_cnt - CW'(1);
                    MODE_RECOVER: r_cnt <= r_kept;
                    default:      r_cnt <= r_cnt;
                endcase
            end
            if (i_cmd.emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[sv/sorted_event_queue.sv]
// Top level: sorted event queue of micro-op completions.
// Input channel i_valid/o_ready takes one word: mode plus entry fields and the
// present cycle. Output channel o_valid/i_ready returns one result word per input.
// Config channel i_cfg_valid/o_cfg_ready writes the miss age threshold; ready out of reset.
// Entries sit in one RAM in key order, slot 0 the head; each operation is a
// scan by the controller, one RAM read and one evaluate per entry visited.
// Entries visited per word: insert, those with a larger key plus the one it lands
// after; extract and recover, every entry held; query, those up to the first hit.
// One word is in work at a time; the RAM read is registered, so each entry visited
// takes its read and its evaluate in separate controller states.
// A finished result waits in the output register; the next word is taken once the
// result has been loaded there, and a stalled receiver holds the block in its
// hand-off state until the output register frees.
// Reset (synchronous, active low) empties the queue, sets the threshold to 5 and
// drops any pending result; RAM contents are not cleared.
`default_nettype none
module sorted_event_queue
    import sevq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_event_time,
    input  wire logic [31:0] i_seq_id,
    input  wire logic [2:0]  i_thread_id,
    input  wire logic        i_speculative,
    input  wire logic        i_is_load,
    input  wire logic [31:0] i_issue_time,
    input  wire logic [31:0] i_current_cycle,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_head_valid,
    output logic [31:0]      o_head_time,
    output logic [31:0]      o_head_id,
    output logic [2:0]       o_head_thread,
    output logic             o_head_speculative,
    output logic             o_head_is_load,
    output logic [31:0]      o_head_issue_time,
    output logic             o_insert_dropped,
    output logic [4:0]       o_removed_count,
    output logic             o_miss_pending,
    output logic [4:0]       o_occupancy
);
    t_cmd   cmd;
    t_stat  stat;
    t_entry in_entry, head;

    assign o_cfg_ready = i_rst_n;

    assign in_entry.event_time  = i_event_time;
    assign in_entry.seq_id      = i_seq_id;
    assign in_entry.thread_id   = i_thread_id;
    assign in_entry.speculative = i_speculative;
    assign in_entry.is_load     = i_is_load;
    assign in_entry.issue_time  = i_issue_time;

    assign o_head_time        = head.event_time;
    assign o_head_id          = head.seq_id;
    assign o_head_thread      = head.thread_id;
    assign o_head_speculative = head.speculative;
    assign o_head_is_load     = head.is_load;
    assign o_head_issue_time  = head.issue_time;

    sevq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    sevq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_entry         (in_entry),
        .i_current_cycle (i_current_cycle),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_head          (head),
        .o_head_valid    (o_head_valid),
        .o_insert_dropped(o_insert_dropped),
        .o_removed_count (o_removed_count),
        .o_miss_pending  (o_miss_pending),
        .o_occupancy     (o_occupancy)
    );
endmodule
`default_nettype wire

[sv/sevq_checker.sv]
// Port-level checker for the sorted event queue, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module sevq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_head_valid,
    input wire logic       o_insert_dropped,
    input wire logic [4:0] o_removed_count,
    input wire logic       o_miss_pending,
    input wire logic [4:0] o_occupancy
);
    `SEVQ_ASSERT(a_stall_hold, o_valid && !i_ready |=> o_valid && $stable(o_occupancy), "result changed while stalled")
    `SEVQ_ASSERT(a_one_kind, o_valid && o_head_valid |-> !o_insert_dropped && o_removed_count == 5'd0 && !o_miss_pending, "extract result mixes fields")
    `SEVQ_ASSERT(a_drop_full, o_valid && o_insert_dropped |-> o_occupancy == 5'(QUEUE_DEPTH) && !o_miss_pending, "drop without full queue")
    `SEVQ_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid, "result valid after reset")
endmodule

bind sorted_event_queue sevq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_sevq_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
// Testbench for the sorted event queue: directed table, then random words, checked against a predictor.
`default_nettype none
module tb_top;
    import sevq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] event_time;
        logic [31:0] seq_id;
        logic [2:0]  thread_id;
        logic        speculative;
        logic        is_load;
        logic [31:0] issue_time;
        logic [31:0] current_cycle;
    } t_op;

    typedef struct packed {
        logic        head_valid;
        logic [31:0] head_time;
        logic [31:0] head_id;
        logic [2:0]  head_thread;
        logic        head_speculative;
        logic        head_is_load;
        logic [31:0] head_issue_time;
        logic        insert_dropped;
        logic [4:0]  removed_count;
        logic        miss_pending;
        logic [4:0]  occupancy;
    } t_res;

    localparam int DEPTH = 16;
    localparam int RANDOM_WORDS = 1430;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_op  op_drv = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [7:0] i_cfg_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    wire t_res res_dut;

    always #2 i_clk = ~i_clk;

    sorted_event_queue i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(op_drv.mode), .i_event_time(op_drv.event_time),
        .i_seq_id(op_drv.seq_id), .i_thread_id(op_drv.thread_id),
        .i_speculative(op_drv.speculative), .i_is_load(op_drv.is_load),
        .i_issue_time(op_drv.issue_time), .i_current_cycle(op_drv.current_cycle),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_head_valid(res_dut.head_valid), .o_head_time(res_dut.head_time),
        .o_head_id(res_dut.head_id), .o_head_thread(res_dut.head_thread),
        .o_head_speculative(res_dut.head_speculative),
        .o_head_is_load(res_dut.head_is_load),
        .o_head_issue_time(res_dut.head_issue_time),
        .o_insert_dropped(res_dut.insert_dropped),
        .o_removed_count(res_dut.removed_count),
        .o_miss_pending(res_dut.miss_pending), .o_occupancy(res_dut.occupancy)
    );

    // predictor state
    t_entry     q_slot[DEPTH];
    int         q_count = 0;
    logic [7:0] q_threshold = THRESHOLD_RESET;

    t_res expected_results[$];
    int   errors = 0;
    int   rx_hold = 0;
    bit   quiet_tail = 0;
    bit   long_hold = 0;
    bit   stim_done = 0;

    function automatic t_res queue_apply(t_op o);
        t_res r;
        int pos;
        int kept;
        int removed;
        r = '0;
        case (o.mode)
            MODE_INSERT: begin
                if (q_count >= DEPTH) begin
                    r.insert_dropped = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < q_count && !({o.event_time, o.seq_id} <
                           {q_slot[pos].event_time, q_slot[pos].seq_id}))
                        pos++;
                    for (int i = q_count; i > pos; i--) q_slot[i] = q_slot[i-1];
                    q_slot[pos] = '{o.event_time, o.seq_id, o.thread_id,
                                    o.speculative, o.is_load, o.issue_time};
                    q_count++;
                end
            end
            MODE_EXTRACT: begin
                if (q_count > 0) begin
                    r.head_valid = 1'b1;
                    r.head_time = q_slot[0].event_time;
                    r.head_id = q_slot[0].seq_id;
                    r.head_thread = q_slot[0].thread_id;
                    r.head_speculative = q_slot[0].speculative;
                    r.head_is_load = q_slot[0].is_load;
                    r.head_issue_time = q_slot[0].issue_time;
                    for (int i = 1; i < q_count; i++) q_slot[i-1] = q_slot[i];
                    q_count--;
                end
            end
            MODE_RECOVER: begin
                kept = 0;
                removed = 0;
                for (int i = 0; i < q_count; i++) begin
                    if (q_slot[i].thread_id == o.thread_id && q_slot[i].speculative) begin
                        removed++;
                    end else begin
                        q_slot[kept] = q_slot[i];
                        kept++;
                    end
                end
                q_count = kept;
                r.removed_count = removed[4:0];
            end
            default: begin
                for (int i = 0; i < q_count; i++)
                    if (q_slot[i].thread_id == o.thread_id && q_slot[i].is_load &&
                        o.current_cycle >= q_slot[i].issue_time &&
                        o.current_cycle - q_slot[i].issue_time > {24'd0, q_threshold})
                        r.miss_pending = 1'b1;
            end
        endcase
        r.occupancy = q_count[4:0];
        return r;
    endfunction

    task automatic send_word(t_op o);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        op_drv <= o;
        do @(posedge i_clk); while (!o_ready);
        expected_results.push_back(queue_apply(o));
    endtask

    task automatic write_threshold(logic [7:0] v);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        q_threshold = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_op rand_op(int bias);
        t_op o;
        int r;
        o.mode = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        if (bias == 0 && r < 5) o.mode = MODE_INSERT;
        if (bias == 1 && r < 5) o.mode = MODE_EXTRACT;
        o.event_time = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
        o.seq_id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5);
        o.thread_id = 3'($urandom_range(0, 7));
        o.speculative = 1'($urandom_range(0, 1));
        o.is_load = 1'($urandom_range(0, 1));
        o.issue_time = ($urandom_range(0, 3) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 300);
        o.current_cycle = ($urandom_range(0, 3) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 300);
        return o;
    endfunction

    // receiver
    initial begin
        t_res exp_r;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, res_dut);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== res_dut) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_r, res_dut);
                        errors++;
                    end
                end
            end
            if (long_hold) begin
                i_ready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                rx_hold = $urandom_range(0, 9);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // directed table: op, check flag, expected
    t_op  dir_op[$];
    t_res dir_res[$];
    bit   dir_chk[$];

    task automatic add_row(t_op o, bit chk, t_res r);
        dir_op.push_back(o);
        dir_chk.push_back(chk);
        dir_res.push_back(r);
    endtask

    initial begin
        t_op o;
        t_res r;
        t_res got;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        o = '0; o.mode = MODE_EXTRACT; r = '0;
        add_row(o, 1'b1, r);                            // empty extract
        o.mode = MODE_RECOVER; add_row(o, 1'b1, r);
        o.mode = MODE_QUERY; add_row(o, 1'b1, r);
        o = '1; o.mode = MODE_INSERT; r = '0; r.occupancy = 5'd1;
        add_row(o, 1'b1, r);                            // max keys
        o = '0; o.mode = MODE_INSERT; r.occupancy = 5'd2;
        add_row(o, 1'b1, r);                            // min keys
        o.mode = MODE_EXTRACT; r = '0; r.head_valid = 1'b1; r.occupancy = 5'd1;
        add_row(o, 1'b1, r);
        for (int i = 0; i < 16; i++) begin
            o = '0; o.mode = MODE_INSERT; o.event_time = 7; o.seq_id = i % 3;
            o.thread_id = i % 2 ? 3'd7 : 3'd0; o.speculative = i[0]; o.is_load = 1'b1;
            o.issue_time = (i == 4) ? 32'hFFFF_FFFF : 32'd100 - i;
            add_row(o, 1'b0, '0);
        end
        o = '0; o.mode = MODE_QUERY; o.thread_id = 3'd0; o.current_cycle = 100 + 5;
        add_row(o, 1'b0, '0);                           // at threshold
        o.current_cycle = 32'hFFFF_FFFF; add_row(o, 1'b0, '0);
        o.mode = MODE_RECOVER; o.thread_id = 3'd7; add_row(o, 1'b0, '0);

        for (int k = 0; k < dir_op.size(); k++) begin
            got = queue_apply(dir_op[k]);
            if (dir_chk[k] && got !== dir_res[k]) begin
                $display("%0t: table mismatch expected %h actual %h",
                         $time, dir_res[k], got);
                errors++;
            end
        end
        q_count = 0;
        foreach (dir_op[k]) send_word(dir_op[k]);

        write_threshold(8'd0);
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) write_threshold(8'd255);
            if (ph == 2) write_threshold(8'($urandom_range(1, 254)));
            if (ph == 3) begin
                write_threshold(THRESHOLD_RESET);
                quiet_tail = 1;
            end
            for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
                if (ph == 1 && n == 20) begin
                    long_hold = 1;
                    fork
                        begin
                            repeat (300) @(posedge i_clk);
                            long_hold = 0;
                        end
                    join_none
                end
                send_word(rand_op((n / 40) % 3));
            end
        end
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #4ms;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
